// ===== src/ifps_pkg.sv =====
// Shared constants, types and state codes of the filtered PWM setpoint core.
package ifps_pkg;

    // Field and format widths.
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 14;
    localparam int COEF_FRAC   = 14;
    localparam int GAIN_W      = 16;
    localparam int COEF_W      = 16;
    localparam int SCALE_W     = 16;
    localparam int LEVEL_W     = 16;
    localparam int SP_W        = 16;
    localparam int PULSE_W     = 16;
    localparam int STEP_W      = 8;
    localparam int Y_W         = 32;
    localparam int Y_ACC_W     = 40;

    // Configuration port.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_BASE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_STEP      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MAX       = 3'd6;

    localparam logic [GAIN_W-1:0]  RST_INPUT_GAIN      = 16'd1493;
    localparam logic [COEF_W-1:0]  RST_FEEDBACK_FIRST  = 16'd27689;
    localparam logic [COEF_W-1:0]  RST_FEEDBACK_SECOND = 16'd11837;
    localparam logic [SCALE_W-1:0] RST_OUTPUT_SCALE    = 16'd16004;
    localparam logic [PULSE_W-1:0] RST_PULSE_BASE      = 16'd10000;
    localparam logic [STEP_W-1:0]  RST_PULSE_STEP      = 8'd10;
    localparam logic [PULSE_W-1:0] RST_PULSE_MAX       = 16'd20000;

    // Digit-serial multiplier geometry.
    localparam int MCAND_W  = Y_W + 1;
    localparam int MPLIER_W = 16;
    localparam int DIGIT_W  = 4;
    localparam int DIGITS   = MPLIER_W / DIGIT_W;
    localparam int DCNT_W   = $clog2(DIGITS);
    localparam int PART_W   = MCAND_W + DIGIT_W + 1;
    localparam int PROD_W   = MCAND_W + MPLIER_W;

    // Alignment of the products to the filter format.
    localparam int GAIN_PROD_W = SAMPLE_BITS + GAIN_W;
    localparam int GAIN_LSH    = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int GAIN_RSH    = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int SP_SHIFT    = FRAC_BITS + SCALE_W;
    localparam int PSUM_W      = SP_W + STEP_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_FB1,
        ST_FB2,
        ST_LEVEL,
        ST_SCALE,
        ST_PULSE,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic start;
        logic coef_signed;
    } t_mul_ctrl;

endpackage

// ===== src/iir_filtered_pwm_setpoint_core.sv =====
// Top level: two-pole low-pass filter on converter samples, scaled to a PWM compare value.
//
// Usage. One converter sample is taken per item on the input channel
// (i_in_valid / o_in_ready, payload i_adc_sample). Each item gives exactly one
// result item on the output channel (o_out_valid / i_out_ready) carrying the
// filter level, the clamped setpoint and the saturated pulse width.
// All multiplication runs through one shared digit-serial multiplier that takes a
// 4-bit digit of its 16-bit multiplier per cycle, and the five products
// (input gain, both feedback terms, setpoint scale, pulse step) pass through it
// one after another. An item is accepted only while the core is idle, so no new
// item enters before the five sequential passes of the last one are through.
// The result sits in an output register: the next item is accepted as soon as
// the previous one has been loaded there, even while the receiver stalls; a
// finished item then waits until that register is free.
// Reset is synchronous and active low: it clears both stored filter outputs,
// the handshakes and the sequencer, and returns the registers to their
// default coefficients. Register writes take effect at once and are expected
// only while the core is idle; an unknown register index is ignored.
module iir_filtered_pwm_setpoint_core (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [ifps_pkg::CFG_INDEX_W-1:0]         i_cfg_index,
    input  logic [ifps_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [ifps_pkg::SAMPLE_BITS-1:0]         i_adc_sample,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [ifps_pkg::LEVEL_W-1:0]      o_filtered_level,
    output logic [ifps_pkg::SP_W-1:0]                o_setpoint_value,
    output logic [ifps_pkg::PULSE_W-1:0]             o_pulse_width
);
    import ifps_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]        r_input_gain;
    logic signed [COEF_W-1:0] r_feedback_first;
    logic signed [COEF_W-1:0] r_feedback_second;
    logic [SCALE_W-1:0]       r_output_scale;
    logic [PULSE_W-1:0]       r_pulse_base;
    logic [STEP_W-1:0]        r_pulse_step;
    logic [PULSE_W-1:0]       r_pulse_max;

    // Sequencer and datapath registers.
    t_state                    r_state;
    t_state                    n_state;
    logic signed [Y_W-1:0]     r_prev;
    logic signed [Y_W-1:0]     r_older;
    logic signed [Y_W-1:0]     r_y;
    logic signed [Y_ACC_W-1:0] r_acc;
    logic signed [LEVEL_W-1:0] r_level;
    logic [SP_W-1:0]           r_sp;
    logic [PULSE_W-1:0]        r_pw;

    // Output register.
    logic                      r_out_valid;
    logic signed [LEVEL_W-1:0] r_out_level;
    logic [SP_W-1:0]           r_out_sp;
    logic [PULSE_W-1:0]        r_out_pw;

    // Multiplier interface.
    t_mul_ctrl                 w_mul_ctrl;
    logic signed [MCAND_W-1:0] w_mcand;
    logic [MPLIER_W-1:0]       w_mplier;
    logic                      w_mul_done;
    logic signed [PROD_W-1:0]  w_prod;

    // Datapath logic.
    logic                      w_in_accept;
    logic                      w_out_free;
    logic [Y_ACC_W-1:0]        w_term_in;
    logic signed [Y_ACC_W-1:0] w_coef_term;
    logic signed [Y_ACC_W-1:0] w_diff;
    logic signed [Y_W-1:0]     w_y_sat;
    logic signed [Y_W-1:0]     w_y_shr;
    logic signed [LEVEL_W-1:0] w_level_sat;
    logic                      w_y_pos;
    logic [PROD_W-1:0]         w_sp_wide;
    logic [SP_W-1:0]           w_sp_sat;
    logic [PSUM_W-1:0]         w_pulse_sum;
    logic [PULSE_W-1:0]        w_pulse_sat;

    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);

    // Register file: a write lands in the cycle it is presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain      <= RST_INPUT_GAIN;
            r_feedback_first  <= RST_FEEDBACK_FIRST;
            r_feedback_second <= RST_FEEDBACK_SECOND;
            r_output_scale    <= RST_OUTPUT_SCALE;
            r_pulse_base      <= RST_PULSE_BASE;
            r_pulse_step      <= RST_PULSE_STEP;
            r_pulse_max       <= RST_PULSE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INPUT_GAIN:      r_input_gain      <= i_cfg_data;
                REG_FEEDBACK_FIRST:  r_feedback_first  <= i_cfg_data;
                REG_FEEDBACK_SECOND: r_feedback_second <= i_cfg_data;
                REG_OUTPUT_SCALE:    r_output_scale    <= i_cfg_data;
                REG_PULSE_BASE:      r_pulse_base      <= i_cfg_data;
                REG_PULSE_STEP:      r_pulse_step      <= i_cfg_data[STEP_W-1:0];
                REG_PULSE_MAX:       r_pulse_max       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Arithmetic around the multiplier. The gain product is unsigned and is
    // brought from Q.16 to the filter's fraction width; the feedback products
    // are floored by the coefficient's fraction width.
    always_comb begin
        w_term_in   = (Y_ACC_W'(w_prod[GAIN_PROD_W-1:0]) << GAIN_LSH) >> GAIN_RSH;
        w_coef_term = Y_ACC_W'(w_prod >>> COEF_FRAC);
        w_diff      = r_acc - w_coef_term;

        // New filter output, held to the signed 32-bit range.
        if ((&w_diff[Y_ACC_W-1:Y_W-1]) || !(|w_diff[Y_ACC_W-1:Y_W-1])) begin
            w_y_sat = w_diff[Y_W-1:0];
        end else if (w_diff[Y_ACC_W-1]) begin
            w_y_sat = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            w_y_sat = {1'b0, {(Y_W-1){1'b1}}};
        end

        // Integer part of the output, floored, held to 16 signed bits.
        w_y_shr = r_y >>> FRAC_BITS;
        if ((&w_y_shr[Y_W-1:LEVEL_W-1]) || !(|w_y_shr[Y_W-1:LEVEL_W-1])) begin
            w_level_sat = w_y_shr[LEVEL_W-1:0];
        end else if (w_y_shr[Y_W-1]) begin
            w_level_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
        end else begin
            w_level_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
        end

        w_y_pos = !r_y[Y_W-1] && (|r_y);

        // Setpoint: the scale product is never negative, since a filter output
        // that is not positive is fed to the multiplier as zero.
        w_sp_wide = $unsigned(w_prod) >> SP_SHIFT;
        if (|w_sp_wide[PROD_W-1:SP_W]) begin
            w_sp_sat = '1;
        end else begin
            w_sp_sat = w_sp_wide[SP_W-1:0];
        end

        // Pulse width: base plus setpoint times step, capped at the configured maximum.
        w_pulse_sum = PSUM_W'(w_prod[SP_W+STEP_W-1:0]) + PSUM_W'(r_pulse_base);
        if (w_pulse_sum > PSUM_W'(r_pulse_max)) begin
            w_pulse_sat = r_pulse_max;
        end else begin
            w_pulse_sat = w_pulse_sum[PULSE_W-1:0];
        end
    end

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_accept) n_state = ST_GAIN;
            ST_GAIN:  if (w_mul_done) n_state = ST_FB1;
            ST_FB1:   if (w_mul_done) n_state = ST_FB2;
            ST_FB2:   if (w_mul_done) n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_SCALE;
            ST_SCALE: if (w_mul_done) n_state = ST_PULSE;
            ST_PULSE: if (w_mul_done) n_state = ST_HOLD;
            ST_HOLD:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer: multiplier operands. The feedback and pulse-step products are
    // launched in the cycle the previous one is collected; the scale product in ST_LEVEL.
    always_comb begin
        w_mul_ctrl = '0;
        w_mcand    = '0;
        w_mplier   = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_mul_ctrl.start = w_in_accept;
                w_mcand          = MCAND_W'(i_adc_sample);
                w_mplier         = r_input_gain;
            end
            ST_GAIN: begin
                w_mul_ctrl.start       = w_mul_done;
                w_mul_ctrl.coef_signed = 1'b1;
                w_mcand                = MCAND_W'(r_prev);
                w_mplier               = r_feedback_first;
            end
            ST_FB1: begin
                w_mul_ctrl.start       = w_mul_done;
                w_mul_ctrl.coef_signed = 1'b1;
                w_mcand                = MCAND_W'(r_older);
                w_mplier               = r_feedback_second;
            end
            ST_LEVEL: begin
                w_mul_ctrl.start = 1'b1;
                w_mcand          = w_y_pos ? MCAND_W'(r_y) : '0;
                w_mplier         = r_output_scale;
            end
            ST_SCALE: begin
                w_mul_ctrl.start = w_mul_done;
                w_mcand          = MCAND_W'(w_sp_sat);
                w_mplier         = MPLIER_W'(r_pulse_step);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prev  <= '0;
            r_older <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FB2 && w_mul_done) begin
                r_older <= r_prev;
                r_prev  <= w_y_sat;
            end
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_GAIN && w_mul_done) begin
            r_acc <= $signed(w_term_in);
        end
        if (r_state == ST_FB1 && w_mul_done) begin
            r_acc <= r_acc + w_coef_term;
        end
        if (r_state == ST_FB2 && w_mul_done) begin
            r_y <= w_y_sat;
        end
        if (r_state == ST_LEVEL) begin
            r_level <= w_level_sat;
        end
        if (r_state == ST_SCALE && w_mul_done) begin
            r_sp <= w_sp_sat;
        end
        if (r_state == ST_PULSE && w_mul_done) begin
            r_pw <= w_pulse_sat;
        end
    end

    // Output register: loaded when the finished item can move on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_HOLD && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_HOLD && w_out_free) begin
            r_out_level <= r_level;
            r_out_sp    <= r_sp;
            r_out_pw    <= r_pw;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_level = r_out_level;
    assign o_setpoint_value = r_out_sp;
    assign o_pulse_width    = r_out_pw;

    ifps_dsmul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_mul_ctrl),
        .i_mcand   (w_mcand),
        .i_mplier  (w_mplier),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == ST_GAIN || r_state == ST_FB1 || r_state == ST_FB2 ||
                        r_state == ST_SCALE || r_state == ST_PULSE))
        else $error("product arrived while the sequencer was not waiting for one");

    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEVEL) |-> (r_older == $past(r_prev)))
        else $error("older filter output does not follow the previous one");

    a_sp_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PULSE && !w_y_pos) |-> (r_sp == '0))
        else $error("setpoint not zero for a filter output that is not positive");

    a_pulse_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_out_pw <= r_pulse_max))
        else $error("pulse width above its limit");

endmodule

// ===== src/ifps_dsmul.sv =====
// Digit-serial shift-and-add multiplier, one 4-bit digit of the multiplier per cycle.
module ifps_dsmul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ifps_pkg::t_mul_ctrl                  i_ctrl,
    input  logic signed [ifps_pkg::MCAND_W-1:0]  i_mcand,
    input  logic [ifps_pkg::MPLIER_W-1:0]        i_mplier,
    output logic                                 o_done,
    output logic signed [ifps_pkg::PROD_W-1:0]   o_product
);
    import ifps_pkg::*;

    logic signed [PART_W-1:0]  r_a;
    logic [MPLIER_W-1:0]       r_q;
    logic signed [MCAND_W-1:0] r_m;
    logic [DCNT_W-1:0]         r_cnt;
    logic                      r_busy;
    logic                      r_signed;
    logic                      r_done;

    logic                      w_last;
    logic signed [DIGIT_W:0]   w_dig;
    logic signed [PART_W-1:0]  w_pp;
    logic signed [PART_W-1:0]  w_sum;

    // The top digit of a signed multiplier carries negative weight.
    always_comb begin
        w_last = (r_cnt == DCNT_W'(DIGITS - 1));
        if (w_last && r_signed) begin
            w_dig = {r_q[DIGIT_W-1], r_q[DIGIT_W-1:0]};
        end else begin
            w_dig = {1'b0, r_q[DIGIT_W-1:0]};
        end
        w_pp  = PART_W'(r_m) * PART_W'(w_dig);
        w_sum = r_a + w_pp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_a      <= '0;
                r_q      <= i_mplier;
                r_m      <= i_mcand;
                r_signed <= i_ctrl.coef_signed;
            end else if (r_busy) begin
                r_a   <= w_sum >>> DIGIT_W;
                r_q   <= {w_sum[DIGIT_W-1:0], r_q[MPLIER_W-1:DIGIT_W]};
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_a[PROD_W-MPLIER_W-1:0], r_q};

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("multiplier started while a product is in progress");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("product reported without a preceding pass");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("product reported on two cycles in a row");

endmodule
